@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/hfrc8_pkg.sv @@
// Constants, codes and helper functions for the hex frame receiver.
package hfrc8_pkg;

	localparam int unsigned FRAME_BYTES_DEF = 17;
	localparam int unsigned HEADER_LEN      = 4;
	localparam int unsigned DIGITS_KEPT     = 12;
	localparam int unsigned DIGIT_W         = 4 * DIGITS_KEPT;
	localparam int unsigned CFG_ADDR_W      = 3;
	localparam int unsigned CFG_DATA_W      = 32;

	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_O_UP  = 8'h4F;
	localparam logic [7:0] CH_O_LO  = 8'h6F;
	localparam logic [7:0] CH_C_UP  = 8'h43;
	localparam logic [7:0] CH_C_LO  = 8'h63;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [7:0] CRC_POLY_RST = 8'h31;
	localparam logic [7:0] CRC_INIT_RST = 8'hFF;

	typedef enum logic {
		REG_CRC_POLY = 1'b0,
		REG_CRC_INIT = 1'b1
	} reg_idx_t;

	// Bit 4 flags a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

	// One byte of CRC-8, MSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] r;
		r = crc ^ data;
		for (int i = 0; i < 8; i++)
			r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
		return r;
	endfunction

endpackage

@@ hw/rtl/hfrc8_rx_if.sv @@
// Handshake channel carrying one received byte per item.
interface hfrc8_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/hfrc8_res_if.sv @@
// Handshake channel carrying one decoded frame per item.
interface hfrc8_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_size;
	logic [7:0]  command;
	logic [15:0] argument;
	logic        crc_ok;
	logic [15:0] bad_frames;

	modport source (output valid, output frame_size, output command, output argument,
		output crc_ok, output bad_frames, input ready);
	modport sink (input valid, input frame_size, input command, input argument,
		input crc_ok, input bad_frames, output ready);
endinterface

@@ hw/rtl/hex_frame_receiver_crc8_check.sv @@
// Top level of the ASCII hex frame receiver with CRC-8 checking.

// Takes one received byte per clock cycle and hunts for frames of the form
// "2OC:" (either case for O and C), hex digits up to position FRAME_BYTES-2
// and a carriage return in the last position. Each completed frame gives one
// item with size, command, argument, the CRC-8 verdict over both check bytes
// and the running bad-frame count. Throughput is one byte per cycle; bytes
// stall only when a frame ends while the previous result still waits at the
// output. An accepted byte is held in the input register, which the frame
// logic reads; the result register is loaded when the carriage return
// advances out of the input register. The input register and the result
// register lie between the carriage return and its result. The
// polynomial and initial remainder are written over the APB port at byte
// addresses 0 and 4 and should only be changed while no frame is in flight.
module hex_frame_receiver_crc8_check #(
	parameter int unsigned FRAME_BYTES = hfrc8_pkg::FRAME_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hfrc8_rx_if.sink                         rx,
	hfrc8_res_if.source                      result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hfrc8_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [hfrc8_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [hfrc8_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready
);
	import hfrc8_pkg::*;

	localparam int unsigned POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(HEADER_LEN);
	localparam logic [POS_W-1:0] POS_KEEP  = POS_W'(HEADER_LEN + DIGITS_KEPT);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_O,
		PH_C,
		PH_COLON,
		PH_DATA
	} phase_t;

	// Configuration registers
	logic [7:0] poly_q;
	logic [7:0] init_q;
	reg_idx_t   cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= CRC_POLY_RST;
			init_q <= CRC_INIT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_CRC_POLY: poly_q <= pwdata[7:0];
				REG_CRC_INIT: init_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CRC_POLY: prdata = {(CFG_DATA_W - 8)'(0), poly_q};
			REG_CRC_INIT: prdata = {(CFG_DATA_W - 8)'(0), init_q};
			default:      prdata = '0;
		endcase
	end

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       advance;
	logic       emit;

	// hold a byte only when it ends a frame while the previous result still waits
	assign advance  = valid_s1 && (!emit || !out_valid_q || result.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
			if (rx.valid)
				byte_s1 <= rx.rx_byte;
		end
	end

	// Frame matching
	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [DIGIT_W-1:0] digits_q, digits_d;
	logic [15:0]        bad_q, bad_d;
	logic [4:0]         hex;
	logic [7:0]         crc_a, crc_b;
	logic               frame_ok;

	assign hex = hex_decode(byte_s1);

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		digits_d = digits_q;
		emit     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == CH_TWO)
					phase_d = PH_O;
			end
			PH_O: begin
				phase_d = (byte_s1 == CH_O_UP || byte_s1 == CH_O_LO) ? PH_C : PH_IDLE;
			end
			PH_C: begin
				phase_d = (byte_s1 == CH_C_UP || byte_s1 == CH_C_LO) ? PH_COLON : PH_IDLE;
			end
			PH_COLON: begin
				if (byte_s1 == CH_COLON) begin
					phase_d  = PH_DATA;
					pos_d    = POS_FIRST;
					digits_d = '0;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_DATA: begin
				if (pos_q != POS_LAST) begin
					if (!hex[4]) begin
						phase_d = PH_IDLE;
					end else begin
						// digits beyond the twelfth are checked but not kept
						if (pos_q < POS_KEEP)
							digits_d = {digits_q[DIGIT_W-5:0], hex[3:0]};
						pos_d = pos_q + POS_W'(1);
					end
				end else begin
					phase_d = PH_IDLE;
					emit    = (byte_s1 == CH_CR);
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	assign crc_a    = crc8_byte(crc8_byte(init_q, digits_q[47:40], poly_q),
		digits_q[39:32], poly_q);
	assign crc_b    = crc8_byte(crc8_byte(init_q, digits_q[23:16], poly_q),
		digits_q[15:8], poly_q);
	assign frame_ok = (crc_a == digits_q[31:24]) && (crc_b == digits_q[7:0]);
	assign bad_d    = bad_q + 16'(!frame_ok);

	// Result register
	logic [7:0]  size_q;
	logic [7:0]  cmd_q;
	logic [15:0] arg_q;
	logic        ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			digits_q    <= '0;
			bad_q       <= '0;
			out_valid_q <= 1'b0;
			size_q      <= '0;
			cmd_q       <= '0;
			arg_q       <= '0;
			ok_q        <= 1'b0;
		end else begin
			if (advance) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				digits_q <= digits_d;
			end
			if (advance && emit) begin
				bad_q       <= bad_d;
				out_valid_q <= 1'b1;
				size_q      <= digits_q[47:40];
				cmd_q       <= digits_q[39:32];
				arg_q       <= digits_q[23:8];
				ok_q        <= frame_ok;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.frame_size = size_q;
	assign result.command    = cmd_q;
	assign result.argument   = arg_q;
	assign result.crc_ok     = ok_q;
	assign result.bad_frames = bad_q;

	`include "assert_macros.svh"

	`ASSERT_NEXT(a_emit_loads_result, clk, arst_n, advance && emit,
		out_valid_q && ok_q == $past(frame_ok), "frame end did not load the verdict")
	`ASSERT_NEXT(a_bad_count_hold, clk, arst_n, !(advance && emit && !frame_ok),
		$stable(bad_q), "bad-frame count moved without a failed frame")
	`ASSERT_SAME(a_pos_in_frame, clk, arst_n, phase_q == PH_DATA,
		pos_q >= POS_FIRST && pos_q <= POS_LAST, "position outside the digit field")
	`ASSERT_SAME(a_emit_at_end, clk, arst_n, emit,
		phase_q == PH_DATA && pos_q == POS_LAST, "result raised before the last position")

endmodule

@@ verif/hex_frame_receiver_crc8_check_test.sv @@
// Self-checking testbench for the hex frame receiver: frame streams, CRC settings, random stalls.
module hex_frame_receiver_crc8_check_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hfrc8_pkg::*;

	localparam int unsigned FRAME_BYTES  = FRAME_BYTES_DEF;
	localparam int unsigned SEGMENTS     = 6;
	localparam int unsigned SEGMENT_LEN  = 210;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_JUNK = 8'h78;

	typedef struct packed {
		logic [7:0]  frame_size;
		logic [7:0]  command;
		logic [15:0] argument;
		logic        crc_ok;
		logic [15:0] bad_frames;
	} frame_result_t;

	typedef enum logic [2:0] {
		HUNT_TWO,
		HUNT_O,
		HUNT_C,
		HUNT_COLON,
		COLLECT
	} hunt_t;

	typedef enum {
		FLAW_NONE,
		FLAW_CRC_HEAD,
		FLAW_CRC_ARG,
		FLAW_DIGIT,
		FLAW_END,
		FLAW_HEADER
	} flaw_t;

	typedef enum {
		CASE_UPPER,
		CASE_LOWER,
		CASE_MIXED
	} letter_case_t;

	// Tracks the header hunt and digit collection, and holds the frames still owed.
	class frame_tracker;
		logic [7:0]    poly;
		logic [7:0]    init;
		hunt_t         phase;
		logic [5:0]    pos;
		logic [47:0]   digits;
		logic [15:0]   bad_count;
		frame_result_t pending_frames[$];
		int unsigned   fail_count;

		function new();
			poly       = CRC_POLY_RST;
			init       = CRC_INIT_RST;
			phase      = HUNT_TWO;
			pos        = '0;
			digits     = '0;
			bad_count  = '0;
			fail_count = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [7:0] value);
			if (idx == REG_CRC_POLY)
				poly = value;
			else
				init = value;
		endfunction

		function logic [7:0] crc_of(logic [15:0] data);
			logic [15:0] r;
			r = data ^ {init, 8'h00};
			for (int i = 0; i < 16; i++)
				r = r[15] ? ({r[14:0], 1'b0} ^ {poly, 8'h00}) : {r[14:0], 1'b0};
			return r[15:8];
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_ZERO + 8'd9)
				return int'(c - CH_ZERO);
			if (c >= CH_A_UP && c <= CH_A_UP + 8'd5)
				return int'(c - CH_A_UP) + 10;
			if (c >= CH_A_LO && c <= CH_A_LO + 8'd5)
				return int'(c - CH_A_LO) + 10;
			return -1;
		endfunction

		function void restart_hunt();
			phase = HUNT_TWO;
			pos   = '0;
		endfunction

		function void take_byte(logic [7:0] c);
			int            h;
			frame_result_t res;
			case (phase)
				HUNT_TWO: begin
					if (c == CH_TWO) begin
						phase = HUNT_O;
						pos   = 6'd1;
					end else
						pos = '0;
				end
				HUNT_O: begin
					if (c == CH_O_UP || c == CH_O_LO) begin
						phase = HUNT_C;
						pos   = 6'd2;
					end else
						restart_hunt();
				end
				HUNT_C: begin
					if (c == CH_C_UP || c == CH_C_LO) begin
						phase = HUNT_COLON;
						pos   = 6'd3;
					end else
						restart_hunt();
				end
				HUNT_COLON: begin
					if (c == CH_COLON) begin
						phase  = COLLECT;
						pos    = 6'(HEADER_LEN);
						digits = '0;
					end else
						restart_hunt();
				end
				COLLECT: begin
					if (pos < FRAME_BYTES - 1) begin
						h = hex_nibble(c);
						if (h < 0)
							restart_hunt();
						else begin
							// digits beyond the kept twelve are only checked
							if (pos < HEADER_LEN + DIGITS_KEPT)
								digits = {digits[43:0], 4'(h)};
							pos = pos + 6'd1;
						end
					end else begin
						restart_hunt();
						if (c == CH_CR) begin
							res.frame_size = digits[47:40];
							res.command    = digits[39:32];
							res.argument   = digits[23:8];
							res.crc_ok     = (crc_of(digits[47:32]) == digits[31:24]) &&
								(crc_of(digits[23:8]) == digits[7:0]);
							if (!res.crc_ok)
								bad_count = bad_count + 16'd1;
							res.bad_frames = bad_count;
							pending_frames.push_back(res);
						end
					end
				end
				default: restart_hunt();
			endcase
		endfunction

		function void check_frame(frame_result_t got);
			frame_result_t want;
			if (pending_frames.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected frame: size %h cmd %h arg %h ok %b bad %0d",
						got.frame_size, got.command, got.argument, got.crc_ok, got.bad_frames);
				return;
			end
			want = pending_frames.pop_front();
			if (got.frame_size !== want.frame_size || got.command !== want.command ||
				got.argument !== want.argument || got.crc_ok !== want.crc_ok ||
				got.bad_frames !== want.bad_frames) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("frame mismatch: expected size %h cmd %h arg %h ok %b bad %0d, got size %h cmd %h arg %h ok %b bad %0d",
						want.frame_size, want.command, want.argument, want.crc_ok,
						want.bad_frames, got.frame_size, got.command, got.argument,
						got.crc_ok, got.bad_frames);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	hfrc8_rx_if  rx_ch();
	hfrc8_res_if res_ch();

	frame_tracker tracker = new();
	logic [7:0]   rx_stream[$];
	int unsigned  send_idle_pct;
	int unsigned  sink_stall_pct;
	int unsigned  cycle_count = 0;

	hex_frame_receiver_crc8_check #(
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && rx_ch.valid && rx_ch.ready)
			tracker.take_byte(rx_ch.rx_byte);
	end

	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.frame_size, res_ch.command, res_ch.argument, res_ch.crc_ok,
				res_ch.bad_frames};
			tracker.check_frame(got);
		end
	end

	function automatic bit letter_low(letter_case_t lc);
		return (lc == CASE_LOWER) || (lc == CASE_MIXED && $urandom_range(1) == 1);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit low);
		if (n < 4'd10)
			return CH_ZERO + 8'(n);
		return (low ? CH_A_LO : CH_A_UP) + 8'(n) - 8'd10;
	endfunction

	// Bias towards the extremes of the field.
	function automatic logic [15:0] field_value(int bits);
		case ($urandom_range(9))
			0: return '0;
			1: return 16'((1 << bits) - 1);
			default: return 16'($urandom_range((1 << bits) - 1));
		endcase
	endfunction

	function automatic void push_frame(logic [7:0] size, logic [7:0] cmd, logic [15:0] arg,
		flaw_t flaw, letter_case_t lc);
		logic [7:0]  frame[FRAME_BYTES];
		logic [47:0] digits;
		logic [7:0]  crc0;
		logic [7:0]  crc1;
		logic [7:0]  bad;
		int          p;
		crc0 = tracker.crc_of({size, cmd});
		crc1 = tracker.crc_of(arg);
		if (flaw == FLAW_CRC_HEAD)
			crc0 ^= 8'($urandom_range(255, 1));
		if (flaw == FLAW_CRC_ARG)
			crc1 ^= 8'($urandom_range(255, 1));
		digits = {size, cmd, crc0, arg, crc1};
		frame[0] = CH_TWO;
		frame[1] = letter_low(lc) ? CH_O_LO : CH_O_UP;
		frame[2] = letter_low(lc) ? CH_C_LO : CH_C_UP;
		frame[3] = CH_COLON;
		for (p = HEADER_LEN; p < FRAME_BYTES - 1; p++)
			frame[p] = hex_char((p < HEADER_LEN + DIGITS_KEPT) ?
				digits[47 - 4 * (p - HEADER_LEN) -: 4] : 4'($urandom_range(15)),
				letter_low(lc));
		frame[FRAME_BYTES - 1] = CH_CR;
		case (flaw)
			FLAW_DIGIT: begin
				do
					bad = 8'($urandom_range(255));
				while (tracker.hex_nibble(bad) >= 0);
				frame[$urandom_range(FRAME_BYTES - 2, HEADER_LEN)] = bad;
			end
			FLAW_END: begin
				do
					bad = 8'($urandom_range(255));
				while (bad == CH_CR);
				frame[FRAME_BYTES - 1] = bad;
			end
			FLAW_HEADER: begin
				p = $urandom_range(3, 1);
				do
					bad = 8'($urandom_range(255));
				while ((p == 1 && (bad == CH_O_UP || bad == CH_O_LO)) ||
					(p == 2 && (bad == CH_C_UP || bad == CH_C_LO)) ||
					(p == 3 && bad == CH_COLON));
				frame[p] = bad;
			end
			default: ;
		endcase
		foreach (frame[i])
			rx_stream.push_back(frame[i]);
	endfunction

	function automatic void push_random_traffic(int unsigned target);
		int unsigned r;
		flaw_t       flaw;
		while (rx_stream.size() < target) begin
			r = $urandom_range(99);
			if (r < 12) begin
				repeat ($urandom_range(3, 1))
					rx_stream.push_back(8'($urandom_range(255)));
			end else begin
				r = $urandom_range(99);
				flaw = (r < 60) ? FLAW_NONE : (r < 72) ? FLAW_CRC_HEAD :
					(r < 82) ? FLAW_CRC_ARG : (r < 90) ? FLAW_DIGIT :
					(r < 96) ? FLAW_END : FLAW_HEADER;
				push_frame(8'(field_value(8)), 8'(field_value(8)), field_value(16), flaw,
					letter_case_t'($urandom_range(2)));
			end
		end
		// leave the hunt idle so the settings may change afterwards
		rx_stream.push_back(CH_JUNK);
	endfunction

	task automatic send_stream();
		while (rx_stream.size() != 0) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle_pct)
				rx_ch.valid <= 1'b0;
			else begin
				rx_ch.valid   <= 1'b1;
				rx_ch.rx_byte <= rx_stream.pop_front();
				do
					@(posedge clk);
				while (!rx_ch.ready);
			end
		end
		@(negedge clk);
		rx_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (tracker.pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [7:0] value);
		logic [CFG_DATA_W-1:0] readback;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(4 * int'(idx));
		pwdata  <= CFG_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		tracker.set_reg(idx, value);
		// read the register straight back
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== CFG_DATA_W'(value)) begin
			tracker.fail_count++;
			if (tracker.fail_count <= REPORT_LIMIT)
				$display("register %s readback: expected %h, got %h", idx.name(),
					CFG_DATA_W'(value), readback);
		end
	endtask

	initial begin
		logic [7:0] poly_set[SEGMENTS];
		logic [7:0] init_set[SEGMENTS];
		poly_set       = '{8'h00, 8'hFF, 8'h07, 8'h00, 8'hFF, 8'h31};
		init_set       = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		res_ch.ready   = 1'b0;
		send_idle_pct  = 27;
		sink_stall_pct = 84;
		poly_set[3]    = 8'($urandom_range(255));
		init_set[3]    = 8'($urandom_range(255));
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset polynomial and initial remainder.
		rx_stream.push_back(CH_JUNK);
		push_frame(8'h00, 8'h00, 16'h0000, FLAW_NONE, CASE_UPPER);
		push_frame(8'hFF, 8'hFF, 16'hFFFF, FLAW_NONE, CASE_LOWER);
		// a doubled '2' loses the whole frame that follows
		rx_stream.push_back(CH_TWO);
		push_frame(8'h12, 8'h34, 16'h5678, FLAW_NONE, CASE_MIXED);
		push_frame(8'h9A, 8'hBC, 16'hDEF0, FLAW_HEADER, CASE_MIXED);
		push_frame(8'h01, 8'h80, 16'h8001, FLAW_CRC_HEAD, CASE_UPPER);
		push_frame(8'h7F, 8'hFE, 16'h7FFE, FLAW_CRC_ARG, CASE_LOWER);
		push_frame(8'h3C, 8'hC3, 16'h0FF0, FLAW_DIGIT, CASE_MIXED);
		push_frame(8'h55, 8'hAA, 16'hAA55, FLAW_END, CASE_MIXED);
		push_frame(8'hA5, 8'h5A, 16'hA55A, FLAW_NONE, CASE_MIXED);
		rx_stream.push_back(CH_JUNK);
		send_stream();
		wait_drained();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct  = 27;
					sink_stall_pct = 84;
				end
				1: begin
					send_idle_pct  = 84;
					sink_stall_pct = 27;
				end
				default: begin
					send_idle_pct  = 0;
					sink_stall_pct = 0;
				end
			endcase
			cfg_write(REG_CRC_POLY, poly_set[seg]);
			cfg_write(REG_CRC_INIT, init_set[seg]);
			push_random_traffic(SEGMENT_LEN);
			send_stream();
			wait_drained();
		end

		if (tracker.fail_count == 0 && tracker.pending_frames.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
